### design/aa2e_pkg.sv
// Package for the anti-aliased 2bpp pixel expander.
// Holds the palette type, register indexes, reset colours and the palette builder.
// No dependencies.
package aa2e_pkg;

  localparam int unsigned ColorW = 16;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned NumCodes = 4;

  localparam logic [ColorW-1:0] FORE_RST = 16'hFFFF;
  localparam logic [ColorW-1:0] BACK_RST = 16'h0000;

  localparam logic [CfgIdxW-1:0] REG_FORE = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_BACK = 1'b1;

  typedef logic [NumCodes-1:0][ColorW-1:0] pal_t;
  typedef logic [1:0]                      code_t;

  // Per channel (fg + bg) / 6 by reciprocal 43/256; brightness sum / 3 by 171/512.
  function automatic pal_t build_pal(logic [ColorW-1:0] fc, logic [ColorW-1:0] bc);
    logic [6:0]  rs, gs, bs;
    logic [12:0] rp, gp, bp;
    logic [3:0]  rt, bt;
    logic [4:0]  gt;
    logic [6:0]  fsum, bsum;
    logic [14:0] fprod, bprod;
    logic [5:0]  fa, ba;
    logic        near;
    logic [5:0]  rk2, bk2, rk3, bk3;
    logic [6:0]  gk2, gk3;
    pal_t        pal;
    rs    = 7'(fc[15:11]) + 7'(bc[15:11]);
    gs    = 7'({fc[10:6], 1'b0}) + 7'({bc[10:6], 1'b0});
    bs    = 7'(fc[4:0]) + 7'(bc[4:0]);
    rp    = 13'(rs) * 13'd43;
    gp    = 13'(gs) * 13'd43;
    bp    = 13'(bs) * 13'd43;
    rt    = rp[11:8];
    gt    = gp[12:8];
    bt    = bp[11:8];
    fsum  = 7'(fc[15:11]) + 7'({fc[10:6], 1'b0}) + 7'(fc[4:0]);
    bsum  = 7'(bc[15:11]) + 7'({bc[10:6], 1'b0}) + 7'(bc[4:0]);
    fprod = 15'(fsum) * 15'd171;
    bprod = 15'(bsum) * 15'd171;
    fa    = fprod[14:9];
    ba    = bprod[14:9];
    near  = (7'(fa) + 7'd5) > 7'(ba);
    rk2   = near ? {rt, 2'b00} : {1'b0, rt, 1'b0};
    gk2   = near ? {gt, 2'b00} : {1'b0, gt, 1'b0};
    bk2   = near ? {bt, 2'b00} : {1'b0, bt, 1'b0};
    rk3   = 6'(rt) + 6'({rt, 1'b0});
    gk3   = 7'(gt) + 7'({gt, 1'b0});
    bk3   = 6'(bt) + 6'({bt, 1'b0});
    pal[0] = fc;
    pal[1] = bc;
    pal[2] = 16'({rk2, 11'b0}) | 16'({gk2, 5'b0}) | 16'(bk2);
    pal[3] = 16'({rk3, 11'b0}) | 16'({gk3, 5'b0}) | 16'(bk3);
    return pal;
  endfunction

  localparam pal_t PAL_RST = build_pal(FORE_RST, BACK_RST);

endpackage

### design/aa2e_if.sv
// Handshake channels of the anti-aliased 2bpp pixel expander.
// Input channel carries one bitmap byte, output channel one pixel. No dependencies.
interface aa2e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] bitmap_byte;
  logic       end_of_image;

  modport source (output valid, output bitmap_byte, output end_of_image, input ready);
  modport sink   (input valid, input bitmap_byte, input end_of_image, output ready);
endinterface

interface aa2e_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_color;
  logic        byte_last;
  logic        image_last;

  modport source (output valid, output pixel_color, output byte_last, output image_last,
                  input ready);
  modport sink   (input valid, input pixel_color, input byte_last, input image_last,
                  output ready);
endinterface

### design/antialiased_2bpp_pixel_expander_core.sv
// Top level of the anti-aliased 2bpp pixel expander.
// Depends on aa2e_pkg, the channel interfaces, aa2e_palette and aa2e_serializer.
//
// Usage:
//   byte_i  takes one bitmap byte per item: four 2-bit pixel codes, bits 7:6
//           first, and an end-of-image flag.
//   pixel_o gives four RGB565 pixel items per byte; byte_last marks the fourth,
//           image_last marks the fourth of a byte flagged as end of image.
//   cfg_*   writes the foreground (index 0) or background (index 1) colour;
//           the palette with both blended shades is rebuilt on the write edge.
// Path: the first pixel of a byte passes through the byte register, then the output register.
// Throughput: one pixel per cycle while pixel_o is taken, set by the single
//   pixel output register; the next byte is taken in the cycle its
//   predecessor's last pixel moves into that register.
// Reset: no item held, foreground white, background black.
// Stall: while pixel_o is not taken, the output register and the byte
//   register hold and byte_i is not ready once a byte is waiting.
module antialiased_2bpp_pixel_expander_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [aa2e_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [aa2e_pkg::ColorW-1:0]  cfg_wdata_i,
  aa2e_in_if.sink                      byte_i,
  aa2e_out_if.source                   pixel_o
);
  import aa2e_pkg::*;

  pal_t pal;

  aa2e_palette u_palette (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pal_o       (pal)
  );

  aa2e_serializer u_serializer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pal_i  (pal),
    .in_i   (byte_i),
    .out_o  (pixel_o)
  );

endmodule

### design/aa2e_palette.sv
// Colour registers and the four-entry palette derived from them.
// Depends on aa2e_pkg.
module aa2e_palette (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [aa2e_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [aa2e_pkg::ColorW-1:0]     cfg_wdata_i,
  output aa2e_pkg::pal_t                  pal_o
);
  import aa2e_pkg::*;

  pal_t              pal_q, pal_d;
  logic [ColorW-1:0] fore_d, back_d;

  always_comb begin
    fore_d = pal_q[0];
    back_d = pal_q[1];
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FORE: fore_d = cfg_wdata_i;
        REG_BACK: back_d = cfg_wdata_i;
        default: ;
      endcase
    end
    pal_d = build_pal(fore_d, back_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_q <= PAL_RST;
    end else if (cfg_we_i) begin
      pal_q <= pal_d;
    end
  end

  assign pal_o = pal_q;

endmodule

### design/aa2e_serializer.sv
// Byte register, pixel counter and output register: one pixel per cycle while the output is taken.
// Depends on aa2e_pkg and the channel interfaces.
module aa2e_serializer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  aa2e_pkg::pal_t pal_i,
  aa2e_in_if.sink        in_i,
  aa2e_out_if.source     out_o
);
  import aa2e_pkg::*;

  logic [7:0]        byte_q;
  logic              eoi_q;
  logic [1:0]        cnt_q;
  logic              busy_q;
  logic              out_valid_q;
  logic [ColorW-1:0] pix_q;
  logic              blast_q, ilast_q;
  logic              advance, accept, last_pix;
  code_t             code;

  assign advance  = busy_q && (!out_valid_q || out_o.ready);
  assign last_pix = (cnt_q == 2'd3);
  assign in_i.ready = !busy_q || (advance && last_pix);
  assign accept   = in_i.valid && in_i.ready;

  always_comb begin
    case (cnt_q)
      2'd0:    code = byte_q[7:6];
      2'd1:    code = byte_q[5:4];
      2'd2:    code = byte_q[3:2];
      default: code = byte_q[1:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (advance) begin
        cnt_q <= cnt_q + 2'd1;
        if (last_pix) begin
          busy_q <= 1'b0;
        end
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_i.bitmap_byte;
      eoi_q  <= in_i.end_of_image;
    end
    if (advance) begin
      pix_q   <= pal_i[code];
      blast_q <= last_pix;
      ilast_q <= last_pix && eoi_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_color = pix_q;
  assign out_o.byte_last   = blast_q;
  assign out_o.image_last  = ilast_q;

endmodule
